@@ hdl/ipt_pkg.sv @@
// Shared types and constants of the inverted page table lookup block.
// Depends on nothing; the design files refer to it by scoped names and the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package ipt_pkg;

  localparam int DEF_FRAME_COUNT = 1024;

  localparam int FRAME_W = 10;
  localparam int PROC_W  = 10;
  localparam int PAGE_W  = 12;
  localparam int ENTRY_W = 24;

  // Entry layout: valid in bit 23, bit 22 unused, process in 21..12, page in 11..0.
  localparam int VALID_POS = 23;
  localparam int PROC_LSB  = 12;
  localparam int PAGE_LSB  = 0;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] frame_number;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/ipt_table.sv @@
// Frame table storage: one write port and one read port with registered read data.
// Depends on ipt_pkg for the entry width.
`timescale 1ns / 1ps
`default_nettype none

module ipt_table #(
  parameter int DEPTH = ipt_pkg::DEF_FRAME_COUNT,
  parameter int IDX_W = 10
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [IDX_W-1:0]            waddr,
  input  wire logic [ipt_pkg::ENTRY_W-1:0] wdata,
  input  wire logic [IDX_W-1:0]            raddr,
  output logic      [ipt_pkg::ENTRY_W-1:0] rdata
);

  logic [ipt_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/ipt_ctrl.sv @@
// Sequencer of the lookup block: clearing pass, entry writes and the frame scan.
// Depends on ipt_pkg; drives the ports of ipt_table.
`timescale 1ns / 1ps
`default_nettype none

module ipt_ctrl #(
  parameter int FRAME_COUNT = ipt_pkg::DEF_FRAME_COUNT,
  parameter int IDX_W       = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_cmd,
  input  wire logic [ipt_pkg::FRAME_W-1:0] in_entry_index,
  input  wire logic [ipt_pkg::ENTRY_W-1:0] in_entry_word,
  input  wire logic [ipt_pkg::PROC_W-1:0]  in_lookup_process,
  input  wire logic [ipt_pkg::PAGE_W-1:0]  in_lookup_page,
  output logic                             mem_we,
  output logic      [IDX_W-1:0]            mem_waddr,
  output logic      [ipt_pkg::ENTRY_W-1:0] mem_wdata,
  output logic      [IDX_W-1:0]            mem_raddr,
  input  wire logic [ipt_pkg::ENTRY_W-1:0] mem_rdata,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output ipt_pkg::res_t                    res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

  ipt_pkg::state_t              state_r, state_nxt;
  logic [IDX_W-1:0]             addr_r, addr_nxt;
  logic [IDX_W-1:0]             rd_idx_r;
  logic                         pend_r, pend_nxt;
  logic [ipt_pkg::PROC_W-1:0]   key_proc_r, key_proc_nxt;
  logic [ipt_pkg::PAGE_W-1:0]   key_page_r, key_page_nxt;
  ipt_pkg::res_t                res_r, res_nxt;
  logic [31:0]                  idx_wide;
  logic                         idx_in_range;
  logic                         hit;
  logic                         scan_end;

  assign idx_wide     = 32'(in_entry_index);
  assign idx_in_range = idx_wide < 32'(FRAME_COUNT);

  // The stored entry at rd_idx_r is compared in the cycle after its read was issued.
  assign hit = mem_rdata[ipt_pkg::VALID_POS] &&
               (mem_rdata[ipt_pkg::PROC_LSB +: ipt_pkg::PROC_W] == key_proc_r) &&
               (mem_rdata[ipt_pkg::PAGE_LSB +: ipt_pkg::PAGE_W] == key_page_r);
  assign scan_end = pend_r && (hit || (rd_idx_r == LAST_IDX));

  assign mem_raddr = addr_r;
  assign res       = res_r;

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    pend_nxt     = 1'b0;
    key_proc_nxt = key_proc_r;
    key_page_nxt = key_page_r;
    res_nxt      = res_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = addr_r;
    mem_wdata    = '0;
    case (state_r)
      ipt_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = ipt_pkg::ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ipt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == ipt_pkg::CMD_LOOKUP) begin
            key_proc_nxt = in_lookup_process;
            key_page_nxt = in_lookup_page;
            addr_nxt     = '0;
            state_nxt    = ipt_pkg::ST_SCAN;
          end else if (idx_in_range) begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(idx_wide);
            mem_wdata = in_entry_word;
          end
        end
      end
      ipt_pkg::ST_SCAN: begin
        if (scan_end) begin
          res_nxt.found        = hit;
          res_nxt.frame_number = hit ? ipt_pkg::FRAME_W'(rd_idx_r) : '0;
          state_nxt            = ipt_pkg::ST_DONE;
        end else begin
          pend_nxt = 1'b1;
          if (addr_r != LAST_IDX) begin
            addr_nxt = addr_r + 1'b1;
          end
        end
      end
      ipt_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ipt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ipt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipt_pkg::ST_CLEAR;
      addr_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= addr_r;
    key_proc_r <= key_proc_nxt;
    key_page_r <= key_page_nxt;
    res_r      <= res_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/inverted_page_table_lookup.sv @@
// Top level of the inverted page table lookup block.
// Depends on ipt_pkg, ipt_table and ipt_ctrl.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake              Payload
//  in_       input      in_valid / in_ready    cmd, entry_index, entry_word,
//                                              lookup_process, lookup_page
//  out_      output     out_valid / out_ready  found, frame_number
//
// A write transfer is taken and stores its entry at once; an index at or beyond
// FRAME_COUNT is dropped. A lookup walks the frame table from frame 0 through the
// single read port of the table memory, one entry per cycle, and stops at the first
// match, then returns to idle once its result is handed on. After reset the sequencer
// writes every entry invalid, and in_ready stays low until that pass ends. A finished
// result sits in the output register while the next item is accepted; the sequencer
// only holds a second result back when that register is still occupied.

module inverted_page_table_lookup #(
  parameter int FRAME_COUNT = ipt_pkg::DEF_FRAME_COUNT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_cmd,
  input  wire logic [ipt_pkg::FRAME_W-1:0] in_entry_index,
  input  wire logic [ipt_pkg::ENTRY_W-1:0] in_entry_word,
  input  wire logic [ipt_pkg::PROC_W-1:0]  in_lookup_process,
  input  wire logic [ipt_pkg::PAGE_W-1:0]  in_lookup_page,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_found,
  output logic      [ipt_pkg::FRAME_W-1:0] out_frame_number
);

  // Address width of the table; a single frame still needs one address bit.
  localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [ipt_pkg::ENTRY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]            mem_raddr;
  logic [ipt_pkg::ENTRY_W-1:0] mem_rdata;
  logic                        res_valid;
  logic                        res_ready;
  ipt_pkg::res_t               res;

  logic                        out_valid_r, out_valid_nxt;
  ipt_pkg::res_t               out_res_r, out_res_nxt;

  ipt_table #(
    .DEPTH (FRAME_COUNT),
    .IDX_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ipt_ctrl #(
    .FRAME_COUNT (FRAME_COUNT),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_entry_index    (in_entry_index),
    .in_entry_word     (in_entry_word),
    .in_lookup_process (in_lookup_process),
    .in_lookup_page    (in_lookup_page),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res               (res)
  );

  // The output register takes a new result whenever it is empty or being drained
  // in the same cycle, so back-to-back results move without a bubble.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_res_r.found;
  assign out_frame_number = out_res_r.frame_number;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the inverted page table lookup block.
// Depends on ipt_pkg and inverted_page_table_lookup, and through it on ipt_table and ipt_ctrl.
`timescale 1ns / 1ps

module testbench;
  import ipt_pkg::*;

  localparam int FRAME_COUNT = DEF_FRAME_COUNT;
  // A lookup that misses walks every frame, and the receiver can stall and the
  // sender can pause on top of that. The limit takes that slowest gap several
  // times over, and it also covers the clearing pass after reset.
  localparam int IDLE_LIMIT = 8 * (FRAME_COUNT + 64);
  localparam int RANDOM_ITEMS = 560;
  localparam int KEY_SLOTS = 16;

  typedef struct packed {
    logic [PROC_W-1:0] proc;
    logic [PAGE_W-1:0] page;
  } key_t;

  typedef enum int {RX_STEADY, RX_CHOPPY, RX_STALLING} rx_mode_t;

  // The scoreboard keeps its own copy of the frame table. It works out each
  // lookup result at the moment the lookup transfer is accepted. The block
  // takes nothing new while a scan runs, so the table cannot change under a
  // lookup.
  class translation_scoreboard;
    logic [ENTRY_W-1:0] frame_table [FRAME_COUNT];
    res_t expected_q [$];
    int unsigned mismatches;

    function new();
      foreach (frame_table[i]) frame_table[i] = '0;
      mismatches = 0;
    endfunction

    function res_t translate(logic [PROC_W-1:0] proc, logic [PAGE_W-1:0] page);
      res_t r;
      logic [ENTRY_W-1:0] e;
      r = '0;
      // Frames are walked in ascending order, so the lowest match wins. Bit 22
      // plays no part in the comparison.
      for (int f = 0; f < FRAME_COUNT && !r.found; f++) begin
        e = frame_table[f];
        if (e[VALID_POS] && e[PROC_LSB +: PROC_W] == proc && e[PAGE_LSB +: PAGE_W] == page) begin
          r.found = 1'b1;
          r.frame_number = f[FRAME_W-1:0];
        end
      end
      return r;
    endfunction

    function void note_transfer(logic cmd, logic [FRAME_W-1:0] index,
                                logic [ENTRY_W-1:0] word, logic [PROC_W-1:0] proc,
                                logic [PAGE_W-1:0] page);
      if (cmd == CMD_WRITE) begin
        if (index < FRAME_COUNT) frame_table[index] = word;
      end else begin
        expected_q.push_back(translate(proc, page));
      end
    endfunction

    function void check_result(logic found, logic [FRAME_W-1:0] frame_number);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result found=%0d frame_number=%0d arrived with none expected",
               found, frame_number);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        mismatches++;
      end
      if (frame_number !== want.frame_number) begin
        $error("frame_number: expected %0d, actual %0d", want.frame_number, frame_number);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_cmd;
  logic [FRAME_W-1:0] in_entry_index;
  logic [ENTRY_W-1:0] in_entry_word;
  logic [PROC_W-1:0] in_lookup_process;
  logic [PAGE_W-1:0] in_lookup_page;
  logic out_valid;
  logic out_ready;
  logic out_found;
  logic [FRAME_W-1:0] out_frame_number;

  translation_scoreboard sb;
  int unsigned idle_cycles = 0;

  inverted_page_table_lookup #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_entry_index(in_entry_index),
    .in_entry_word(in_entry_word),
    .in_lookup_process(in_lookup_process),
    .in_lookup_page(in_lookup_page),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_found(out_found),
    .out_frame_number(out_frame_number)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Present one item and hold it until the block takes the transfer. The
  // caller returns at the accepting edge. A following item can then be
  // placed at that same edge, and valid stays high without a dip.
  task automatic send_item(input logic cmd, input logic [FRAME_W-1:0] index,
                           input logic [ENTRY_W-1:0] word,
                           input logic [PROC_W-1:0] proc,
                           input logic [PAGE_W-1:0] page);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_entry_index <= index;
    in_entry_word <= word;
    in_lookup_process <= proc;
    in_lookup_page <= page;
    do @(posedge clk); while (!in_ready);
  endtask

  // The lookup fields of a write carry random values, because the block must
  // ignore them.
  task automatic write_entry(input logic [FRAME_W-1:0] index, input logic valid,
                             input logic spare, input logic [PROC_W-1:0] proc,
                             input logic [PAGE_W-1:0] page);
    send_item(CMD_WRITE, index, {valid, spare, proc, page}, PROC_W'($urandom),
              PAGE_W'($urandom));
  endtask

  // In the same way, the entry fields of a lookup carry random values.
  task automatic request_lookup(input logic [PROC_W-1:0] proc,
                                input logic [PAGE_W-1:0] page);
    send_item(CMD_LOOKUP, FRAME_W'($urandom), ENTRY_W'($urandom), proc, page);
  endtask

  // A gap of zero leaves valid alone, so a burst can run back to back.
  task automatic idle_for(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Lower valid and wait at least one edge, then wait until every lookup in
  // flight has returned its result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // The receiver changes its behavior from time to time. It can be always
  // ready, it can toggle ready in short random steps, or it can hold long
  // stalls with brief ready windows between them.
  rx_mode_t rx_mode = RX_STEADY;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(64, 512);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
    end else begin
      case (rx_mode)
        RX_STEADY: begin
          out_ready <= 1'b1;
          hold_left = 0;
        end
        RX_CHOPPY: begin
          out_ready <= 1'($urandom_range(0, 1));
          hold_left = $urandom_range(0, 2);
        end
        default: begin
          if (out_ready) begin
            out_ready <= 1'b0;
            hold_left = $urandom_range(4, 39);
          end else begin
            out_ready <= 1'b1;
            hold_left = $urandom_range(0, 3);
          end
        end
      endcase
    end
  end

  // Both channels are sampled at the rising edge. The values read here are
  // the ones from before the edge, which are also the values the block saw.
  // The watchdog ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_transfer(in_cmd, in_entry_index, in_entry_word, in_lookup_process,
                         in_lookup_page);
      if (out_valid && out_ready)
        sb.check_result(out_found, out_frame_number);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    key_t key_pool [KEY_SLOTS];
    key_t key;
    logic [FRAME_W-1:0] index;
    int unsigned sent;
    int unsigned burst;
    int unsigned pick;

    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_WRITE;
    in_entry_index <= '0;
    in_entry_word <= '0;
    in_lookup_process <= '0;
    in_lookup_page <= '0;
    out_ready <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // After reset the block clears its table, and in_ready stays low until
    // that is done. The first transfer waits for it.

    // Directed items. A cleared table holds all-zero words, so process 0 and
    // page 0 must not match before anything is written.
    request_lookup('0, '0);
    request_lookup('1, '1);
    write_entry(10'd0, 1'b1, 1'b0, '0, '0);
    request_lookup('0, '0);
    // The top frame, with the spare bit set, found by a full-length walk.
    write_entry(FRAME_W'(FRAME_COUNT - 1), 1'b1, 1'b1, '1, '1);
    idle_for($urandom_range(0, 2));
    request_lookup('1, '1);
    // Clearing the valid bit hides an entry whose fields still match.
    write_entry(FRAME_W'(FRAME_COUNT - 1), 1'b0, 1'b1, '1, '1);
    request_lookup('1, '1);
    // With two matching frames the lower one wins. Once it is removed,
    // the other one is found.
    write_entry(10'd700, 1'b1, 1'b0, 10'h155, 12'haaa);
    write_entry(10'd300, 1'b1, 1'b0, 10'h155, 12'haaa);
    request_lookup(10'h155, 12'haaa);
    idle_for($urandom_range(0, 2));
    write_entry(10'd300, 1'b0, 1'b0, 10'h155, 12'haaa);
    request_lookup(10'h155, 12'haaa);
    // A lookup matches only when both the process and the page agree.
    write_entry(10'd5, 1'b1, 1'b0, 10'h2aa, 12'h555);
    request_lookup(10'h2aa, 12'h554);
    request_lookup(10'h2ab, 12'h555);
    request_lookup(10'h2aa, 12'h555);
    // An all-ones word in a low frame is found; the top frame holds no valid match.
    write_entry(10'd2, 1'b1, 1'b1, '1, '1);
    request_lookup('1, '1);
    write_entry(10'd0, 1'b1, 1'b1, '0, '0);
    request_lookup('0, '0);
    // The index field is only ten bits wide, so at the default table size a
    // write index can never be out of range.
    wait_drained();

    // Random part. Writes and lookups mostly draw on a small pool of keys, so
    // hits, repeated matches and near misses come up often. A few items use
    // fully random keys, so that every bit of every field is exercised.
    foreach (key_pool[i]) key_pool[i] = key_t'($urandom);
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        if ($urandom_range(0, 49) == 0)
          key_pool[$urandom_range(0, KEY_SLOTS - 1)] = key_t'($urandom);
        if ($urandom_range(0, 99) < 45) begin
          case ($urandom_range(0, 3))
            0: index = FRAME_W'($urandom_range(0, 31));
            1: index = FRAME_W'($urandom_range(FRAME_COUNT - 32, FRAME_COUNT - 1));
            default: index = FRAME_W'($urandom);
          endcase
          if ($urandom_range(0, 4) == 0)
            key = key_t'($urandom);
          else
            key = key_pool[$urandom_range(0, KEY_SLOTS - 1)];
          write_entry(index, $urandom_range(0, 6) != 0, 1'($urandom_range(0, 1)),
                      key.proc, key.page);
        end else begin
          pick = $urandom_range(0, 9);
          key = key_pool[$urandom_range(0, KEY_SLOTS - 1)];
          if (pick == 9)
            key = key_t'($urandom);
          else if (pick >= 7)
            key = key ^ (22'd1 << $urandom_range(0, PROC_W + PAGE_W - 1));
          request_lookup(key.proc, key.page);
        end
        sent++;
        // Once, halfway through, the sender holds off until every result is back.
        if (sent == RANDOM_ITEMS / 2) wait_drained();
      end
      idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
    end

    wait_drained();
    // Leave room for a stray result. A full scan is the longest the block can take.
    repeat (FRAME_COUNT + 16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
